// File: sv/mtcf_pkg.sv
`default_nettype none

package mtcf_pkg;

  // Track table and result limits.
  localparam int DEF_TRACK_COUNT = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int CNT_W           = 5;

  // Field widths.
  localparam int TRK_W  = 4;
  localparam int KIND_W = 3;
  localparam int VOL_W  = 17;
  localparam int GAIN_W = 9;
  localparam int LVL_W  = 8;
  localparam int BASE_W = 8;
  localparam int PROD_W = BASE_W + GAIN_W;
  localparam int MUL2_W = PROD_W + GAIN_W;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Q16 volume constants, full channel level and Q8 unity gain.
  localparam logic [VOL_W-1:0] Q16_ONE    = 17'h10000;
  localparam logic [VOL_W-1:0] STEP_RESET = 17'd655;
  localparam logic [LVL_W-1:0] FULL_LEVEL = 8'd128;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 9'd256;

  // Input kind codes.
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PLAY    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_UNLOAD  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_REFRESH = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_ALL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_MUSIC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_STEP    = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_PLAY,
    OP_STOP,
    OP_RESTART,
    OP_LOAD,
    OP_UNLOAD,
    OP_REFRESH
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [TRK_W-1:0] idx;
    logic             valid;
    logic [VOL_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] music_gain;
    logic [GAIN_W-1:0] global_gain;
    logic              mute;
    logic [VOL_W-1:0]  default_step;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/mtcf_front.sv
`default_nettype none

module mtcf_front #(
  parameter int TRACK_COUNT = mtcf_pkg::DEF_TRACK_COUNT
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  // track_index[3:0], track_valid[4], fade_step[21:5], zero pad
  input  wire [mtcf_pkg::IN_DATA_W-1:0] in_tdata,
  // kind[2:0]
  input  wire [mtcf_pkg::KIND_W-1:0]    in_tuser,
  output mtcf_pkg::cmd_t                cmd,
  output logic                          cmd_valid,
  input  wire                           cmd_pop
);
  import mtcf_pkg::*;

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t              dec;
  logic              push;
  logic              pop;

  // Decode one beat into a command; unused kinds are dropped here.
  always_comb begin
    dec.idx   = in_tdata[TRK_W-1:0];
    dec.valid = in_tdata[TRK_W] && (int'(in_tdata[TRK_W-1:0]) < TRACK_COUNT);
    dec.step  = in_tdata[TRK_W+VOL_W:TRK_W+1];
    case (in_tuser)
      KIND_TICK:    dec.op = OP_TICK;
      KIND_PLAY:    dec.op = OP_PLAY;
      KIND_STOP:    dec.op = OP_STOP;
      KIND_RESTART: dec.op = OP_RESTART;
      KIND_LOAD:    dec.op = OP_LOAD;
      KIND_UNLOAD:  dec.op = OP_UNLOAD;
      KIND_REFRESH: dec.op = OP_REFRESH;
      default:      dec.op = OP_NONE;
    endcase
  end

  assign in_tready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready && (dec.op != OP_NONE);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/mtcf_back.sv
`default_nettype none

module mtcf_back #(
  parameter int TRACK_COUNT = mtcf_pkg::DEF_TRACK_COUNT
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  mtcf_pkg::cmd_t                 cmd,
  input  wire                            cmd_valid,
  output logic                           cmd_pop,
  input  mtcf_pkg::cfg_t                 cfg,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // out_track[3:0], level[11:4], restart_flag[12], zero pad
  output logic [mtcf_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import mtcf_pkg::*;

  localparam int IDX_W = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(TRACK_COUNT - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_UPD   = 7'b0000100,
    S_SWEEP = 7'b0001000,
    S_MUL1  = 7'b0010000,
    S_MUL2  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Command being carried out.
  op_t              op_r, op_nxt;
  logic [IDX_W-1:0] cidx_r, cidx_nxt;
  logic             cvalid_r, cvalid_nxt;
  logic [VOL_W-1:0] cstep_r, cstep_nxt;

  logic [IDX_W-1:0] i_r, i_nxt;
  logic             pass_r, pass_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Track flags and written marks for the two stores.
  logic [TRACK_COUNT-1:0] loaded_r, loaded_nxt;
  logic [TRACK_COUNT-1:0] playing_r, playing_nxt;
  logic [TRACK_COUNT-1:0] vinit_r, vinit_nxt;
  logic [TRACK_COUNT-1:0] sinit_r, sinit_nxt;

  logic [VOL_W-1:0] vol_mem  [TRACK_COUNT];
  logic [VOL_W-1:0] step_mem [TRACK_COUNT];
  logic [VOL_W-1:0] vol_rd_r;
  logic [VOL_W-1:0] step_rd_r;
  logic             vol_we, step_we;
  logic [IDX_W-1:0] vol_wa, step_wa;
  logic [VOL_W-1:0] vol_wd, step_wd;

  // Result under construction.
  logic [TRK_W-1:0]  res_trk_r, res_trk_nxt;
  logic              res_rst_r, res_rst_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  // One held result, so that the last flag can be set once the walk ends.
  logic              pnd_vld_r, pnd_vld_nxt;
  logic [TRK_W-1:0]  pnd_trk_r, pnd_trk_nxt;
  logic [LVL_W-1:0]  pnd_lvl_r, pnd_lvl_nxt;
  logic              pnd_rst_r, pnd_rst_nxt;

  // Output register.
  logic              out_vld_r, out_vld_nxt;
  logic [TRK_W-1:0]  out_trk_r, out_trk_nxt;
  logic [LVL_W-1:0]  out_lvl_r, out_lvl_nxt;
  logic              out_rst_r, out_rst_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free;

  // Walk advance.
  state_t            adv_state;
  logic [IDX_W-1:0]  adv_i;
  logic              adv_pass;
  logic              at_end;

  logic [VOL_W-1:0]  vol_cur, step_cur, newv;
  logic [VOL_W:0]    sum;
  logic              hit;
  logic [IDX_W-1:0]  new_cidx;
  logic [MUL2_W-1:0] mul2;
  logic [LVL_W+1:0]  lvl_q;
  logic [LVL_W-1:0]  lvl;
  logic              start_trk, stop_trk;

  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_DATA_W - TRK_W - LVL_W - 1)'(0), out_rst_r, out_lvl_r, out_trk_r};

  assign at_end   = (i_r == LAST_I);
  assign new_cidx = IDX_W'(cmd.idx);
  assign vol_cur  = vinit_r[i_r] ? vol_rd_r : '0;
  assign step_cur = sinit_r[i_r] ? step_rd_r : STEP_RESET;
  assign sum      = {1'b0, vol_cur} + {1'b0, step_cur};

  always_comb begin
    mul2  = prod_r * cfg.global_gain;
    lvl_q = mul2[MUL2_W-1:16];
    if (cfg.mute) begin
      lvl = '0;
    end else if (lvl_q > (LVL_W+2)'(FULL_LEVEL)) begin
      lvl = FULL_LEVEL;
    end else begin
      lvl = lvl_q[LVL_W-1:0];
    end
  end

  always_comb begin
    adv_i    = i_r;
    adv_pass = pass_r;
    if (op_r == OP_RESTART || op_r == OP_LOAD) begin
      adv_state = S_FIN;
    end else if (at_end) begin
      if (op_r == OP_TICK && !pass_r) begin
        adv_pass  = 1'b1;
        adv_i     = '0;
        adv_state = S_RD;
      end else begin
        adv_state = S_FIN;
      end
    end else begin
      adv_i     = i_r + IDX_W'(1);
      adv_state = S_RD;
    end
  end

  // Per-track update during a tick, refresh or restart.
  always_comb begin
    hit  = 1'b0;
    newv = vol_cur;
    case (op_r)
      OP_TICK: begin
        if (!pass_r) begin
          hit  = playing_r[i_r] && (vol_cur < Q16_ONE);
          newv = (sum > {1'b0, Q16_ONE}) ? Q16_ONE : sum[VOL_W-1:0];
        end else begin
          hit  = !playing_r[i_r] && (vol_cur != '0);
          newv = (step_cur >= vol_cur) ? '0 : vol_cur - step_cur;
        end
      end
      OP_REFRESH, OP_RESTART: begin
        hit = 1'b1;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign start_trk = (op_r == OP_PLAY) && cvalid_r && (i_r == cidx_r) && loaded_r[i_r];
  assign stop_trk  = loaded_r[i_r] && playing_r[i_r];

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    cidx_nxt    = cidx_r;
    cvalid_nxt  = cvalid_r;
    cstep_nxt   = cstep_r;
    i_nxt       = i_r;
    pass_nxt    = pass_r;
    cnt_nxt     = cnt_r;
    loaded_nxt  = loaded_r;
    playing_nxt = playing_r;
    vinit_nxt   = vinit_r;
    sinit_nxt   = sinit_r;
    res_trk_nxt = res_trk_r;
    res_rst_nxt = res_rst_r;
    base_nxt    = base_r;
    prod_nxt    = prod_r;
    pnd_vld_nxt = pnd_vld_r;
    pnd_trk_nxt = pnd_trk_r;
    pnd_lvl_nxt = pnd_lvl_r;
    pnd_rst_nxt = pnd_rst_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_trk_nxt = out_trk_r;
    out_lvl_nxt = out_lvl_r;
    out_rst_nxt = out_rst_r;
    out_last_nxt = out_last_r;
    cmd_pop     = 1'b0;
    vol_we      = 1'b0;
    vol_wa      = i_r;
    vol_wd      = newv;
    step_we     = 1'b0;
    step_wa     = i_r;
    step_wd     = cstep_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          op_nxt     = cmd.op;
          cidx_nxt   = new_cidx;
          cvalid_nxt = cmd.valid;
          cstep_nxt  = cmd.step;
          cnt_nxt    = '0;
          pass_nxt   = 1'b0;
          i_nxt      = '0;
          case (cmd.op)
            OP_TICK, OP_REFRESH: begin
              state_nxt = S_RD;
            end
            OP_PLAY, OP_STOP: begin
              state_nxt = S_SWEEP;
            end
            OP_RESTART: begin
              if (cmd.valid && loaded_r[new_cidx]) begin
                i_nxt     = new_cidx;
                state_nxt = S_RD;
              end
            end
            OP_LOAD: begin
              if (cmd.valid) begin
                vol_we                = 1'b1;
                vol_wa                = new_cidx;
                vol_wd                = '0;
                step_we               = 1'b1;
                step_wa               = new_cidx;
                step_wd               = cfg.default_step;
                vinit_nxt[new_cidx]   = 1'b1;
                sinit_nxt[new_cidx]   = 1'b1;
                loaded_nxt[new_cidx]  = 1'b1;
                playing_nxt[new_cidx] = 1'b0;
                res_trk_nxt           = cmd.idx;
                res_rst_nxt           = 1'b1;
                base_nxt              = '0;
                state_nxt             = S_MUL1;
              end
            end
            OP_UNLOAD: begin
              if (cmd.valid && loaded_r[new_cidx]) begin
                loaded_nxt[new_cidx]  = 1'b0;
                playing_nxt[new_cidx] = 1'b0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_UPD;
      end

      S_UPD: begin
        if (hit && op_r == OP_TICK) begin
          vol_we         = 1'b1;
          vinit_nxt[i_r] = 1'b1;
        end
        if (hit && cnt_r < CNT_W'(MAX_RESULTS)) begin
          base_nxt    = newv[VOL_W-1:VOL_W-BASE_W];
          res_trk_nxt = TRK_W'(i_r);
          res_rst_nxt = (op_r == OP_RESTART);
          cnt_nxt     = cnt_r + CNT_W'(1);
          state_nxt   = S_MUL1;
        end else begin
          i_nxt     = adv_i;
          pass_nxt  = adv_pass;
          state_nxt = adv_state;
        end
      end

      S_SWEEP: begin
        if (start_trk) begin
          playing_nxt[i_r] = 1'b1;
        end else if (stop_trk) begin
          playing_nxt[i_r] = 1'b0;
        end
        if ((start_trk || stop_trk) && cstep_r != '0) begin
          step_we        = 1'b1;
          sinit_nxt[i_r] = 1'b1;
        end
        if (at_end) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end

      S_MUL1: begin
        prod_nxt  = base_r * cfg.music_gain;
        state_nxt = S_MUL2;
      end

      S_MUL2: begin
        if (!pnd_vld_r || out_free) begin
          if (pnd_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_trk_nxt  = pnd_trk_r;
            out_lvl_nxt  = pnd_lvl_r;
            out_rst_nxt  = pnd_rst_r;
            out_last_nxt = 1'b0;
          end
          pnd_vld_nxt = 1'b1;
          pnd_trk_nxt = res_trk_r;
          pnd_lvl_nxt = lvl;
          pnd_rst_nxt = res_rst_r;
          i_nxt       = adv_i;
          pass_nxt    = adv_pass;
          state_nxt   = adv_state;
        end
      end

      S_FIN: begin
        if (!pnd_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_trk_nxt  = pnd_trk_r;
          out_lvl_nxt  = pnd_lvl_r;
          out_rst_nxt  = pnd_rst_r;
          out_last_nxt = 1'b1;
          pnd_vld_nxt  = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vol_we) begin
      vol_mem[vol_wa] <= vol_wd;
    end
    vol_rd_r <= vol_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (step_we) begin
      step_mem[step_wa] <= step_wd;
    end
    step_rd_r <= step_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= OP_NONE;
      i_r       <= '0;
      pass_r    <= 1'b0;
      cnt_r     <= '0;
      loaded_r  <= '0;
      playing_r <= '0;
      vinit_r   <= '0;
      sinit_r   <= '0;
      pnd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      op_r      <= op_nxt;
      i_r       <= i_nxt;
      pass_r    <= pass_nxt;
      cnt_r     <= cnt_nxt;
      loaded_r  <= loaded_nxt;
      playing_r <= playing_nxt;
      vinit_r   <= vinit_nxt;
      sinit_r   <= sinit_nxt;
      pnd_vld_r <= pnd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cidx_r     <= cidx_nxt;
    cvalid_r   <= cvalid_nxt;
    cstep_r    <= cstep_nxt;
    res_trk_r  <= res_trk_nxt;
    res_rst_r  <= res_rst_nxt;
    base_r     <= base_nxt;
    prod_r     <= prod_nxt;
    pnd_trk_r  <= pnd_trk_nxt;
    pnd_lvl_r  <= pnd_lvl_nxt;
    pnd_rst_r  <= pnd_rst_nxt;
    out_trk_r  <= out_trk_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_rst_r  <= out_rst_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// File: sv/multi_track_crossfade_ramp.sv
`default_nettype none

// Multi-track crossfade ramp. Each input beat is a command (kind in tuser):
// a tick ramps playing tracks up toward full volume and stopped tracks down
// toward silence, play stops every playing track and starts one, stop stops
// all, restart and load report one track, unload drops a track and refresh
// reports every track. Each report is a result beat carrying the track, its
// channel level (volume times 128, scaled by the two Q8 gains, saturated at
// 128, zero when muted) and a restart flag; tlast marks the final result of
// a command. A front stage decodes beats into a four-deep command queue, so
// the input keeps accepting while the back engine works, until the queue is
// full. The engine walks the track table one track at a time through its
// volume and step memories: each track visited is read, then updated, and
// each result passes the two gain multiplier stages; a walk closes in
// S_FIN. A tick visits all tracks twice, refresh visits all once, and
// play and stop sweep every track once. At most sixteen results follow
// one command. Configuration registers are to be written only while the
// block is idle.

module multi_track_crossfade_ramp #(
  parameter int TRACK_COUNT = mtcf_pkg::DEF_TRACK_COUNT
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // Command beats.
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // track_index[3:0], track_valid[4], fade_step[21:5], zero pad [23:22]
  input  wire [mtcf_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind[2:0]
  input  wire [mtcf_pkg::KIND_W-1:0]      in_tuser,
  // Result beats.
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // out_track[3:0], level[11:4], restart_flag[12], zero pad [15:13]
  output logic [mtcf_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // Configuration writes.
  input  wire                             cfg_we,
  input  wire [mtcf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire [mtcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mtcf_pkg::*;

  logic [GAIN_W-1:0] music_gain_r;
  logic [GAIN_W-1:0] global_gain_r;
  logic              mute_all_r;
  logic              mute_music_r;
  logic [VOL_W-1:0]  def_step_r;

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      music_gain_r  <= GAIN_ONE;
      global_gain_r <= GAIN_ONE;
      mute_all_r    <= 1'b0;
      mute_music_r  <= 1'b0;
      def_step_r    <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MUSIC_GAIN:  music_gain_r  <= cfg_data[GAIN_W-1:0];
        CFG_GLOBAL_GAIN: global_gain_r <= cfg_data[GAIN_W-1:0];
        CFG_MUTE_ALL:    mute_all_r    <= cfg_data[0];
        CFG_MUTE_MUSIC:  mute_music_r  <= cfg_data[0];
        CFG_DEF_STEP:    def_step_r    <= cfg_data[VOL_W-1:0];
        default:         ;
      endcase
    end
  end

  // Both mutes have the same effect on the level, so they merge here.
  always_comb begin
    cfg.music_gain   = music_gain_r;
    cfg.global_gain  = global_gain_r;
    cfg.mute         = mute_all_r || mute_music_r;
    cfg.default_step = def_step_r;
  end

  mtcf_front #(
    .TRACK_COUNT(TRACK_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  mtcf_back #(
    .TRACK_COUNT(TRACK_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the multi-track crossfade ramp.
//
// An initial block queues command beats phase by phase. A clocked driver
// presents them on the input stream, and a clocked monitor checks every
// result beat against a queue of expected level reports. The expected
// reports come from a track-table model that lives in this module. The
// model is advanced once for each command beat that the block accepts, in
// acceptance order, so it sees the same command sequence as the hardware.
//
// Configuration is only rewritten between phases. Before a write the bench
// waits until the input side is empty and every expected report has
// arrived. It then waits a further pause, because play, stop and unload
// produce no result but still keep the engine busy for a while.
module tb_top;
  import mtcf_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_LEN   = 8;
  // A tick that reports nothing still walks the whole table twice, and up
  // to five commands that report nothing (four queued, one running) can
  // remain once the last report is in.
  localparam int SETTLE_LEN  = 500;
  // No handshake for this many cycles while work is pending ends the run.
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_LEN    = 300;
  localparam int RAND_ITEMS  = 88;
  localparam int N_TRACKS    = 16;
  localparam int REPORT_MAX  = 16;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TRK_W-1:0]  idx;
    logic              valid;
    logic [VOL_W-1:0]  step;
  } track_cmd_t;

  typedef struct packed {
    logic [TRK_W-1:0] trk;
    logic [LVL_W-1:0] level;
    logic             restart;
    logic             last;
  } level_report_t;

  // Every input to the block starts at a known value.
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Configuration as the model sees it.
  logic [31:0]      music_gain_q8  = 32'd256;
  logic [31:0]      global_gain_q8 = 32'd256;
  logic             mute_all_on    = 1'b0;
  logic             mute_music_on  = 1'b0;
  logic [VOL_W-1:0] load_step      = STEP_RESET;

  // Track table model.
  logic             trk_loaded  [N_TRACKS];
  logic             trk_playing [N_TRACKS];
  logic [VOL_W-1:0] trk_volume  [N_TRACKS];
  logic [VOL_W-1:0] trk_step    [N_TRACKS];

  track_cmd_t    cmd_backlog[$];
  level_report_t level_reports[$];
  track_cmd_t    cmd_on_bus;
  int            reports_this_cmd;

  bit cmd_taken     = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int err_count     = 0;
  int stall_cycles  = 0;

  multi_track_crossfade_ramp u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // Track table model
  // ---------------------------------------------------------------------

  // Append at the tail of the two queues.
  function automatic void append_report(input level_report_t rpt);
    level_reports.insert(level_reports.size(), rpt);
  endfunction

  function automatic void append_cmd(input track_cmd_t c);
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  // Channel level of a Q16 volume: floor(vol * 128) scaled by both Q8
  // gains, saturated at full level, and forced to zero by either mute.
  function automatic logic [LVL_W-1:0] channel_level(input logic [VOL_W-1:0] vol);
    logic [31:0] base;
    logic [31:0] scaled;
    base = ({15'd0, vol} * 32'd128) >> 16;
    if (mute_all_on || mute_music_on) return '0;
    scaled = (base * music_gain_q8 * global_gain_q8) >> 16;
    return (scaled > 32'd128) ? FULL_LEVEL : scaled[LVL_W-1:0];
  endfunction

  // Queue one report for a track unless this command already hit the cap.
  function automatic void add_report(input int trk, input logic restart);
    level_report_t rpt;
    if (reports_this_cmd < REPORT_MAX) begin
      rpt.trk     = trk[TRK_W-1:0];
      rpt.level   = channel_level(trk_volume[trk]);
      rpt.restart = restart;
      rpt.last    = 1'b0;
      append_report(rpt);
    end
    reports_this_cmd++;
  endfunction

  // Every loaded, playing track stops; a nonzero fade step replaces its step.
  function automatic void stop_playing(input logic [VOL_W-1:0] step);
    for (int i = 0; i < N_TRACKS; i++) begin
      if (trk_loaded[i] && trk_playing[i]) begin
        trk_playing[i] = 1'b0;
        if (step != '0) trk_step[i] = step;
      end
    end
  endfunction

  // Advance the track table by one accepted command and queue the reports
  // it causes, marking the final one as the end of the command.
  function automatic void apply_command(input track_cmd_t c);
    logic [VOL_W:0] sum;
    level_report_t  tail;
    reports_this_cmd = 0;
    case (c.kind)
      KIND_TICK: begin
        // Fade-ins first, then fade-outs, each in track order.
        for (int i = 0; i < N_TRACKS; i++) begin
          if (trk_playing[i] && trk_volume[i] < Q16_ONE) begin
            sum = {1'b0, trk_volume[i]} + {1'b0, trk_step[i]};
            trk_volume[i] = (sum > {1'b0, Q16_ONE}) ? Q16_ONE : sum[VOL_W-1:0];
            add_report(i, 1'b0);
          end
        end
        for (int i = 0; i < N_TRACKS; i++) begin
          if (!trk_playing[i] && trk_volume[i] != '0) begin
            trk_volume[i] = (trk_step[i] >= trk_volume[i]) ? '0
                                                             : trk_volume[i] - trk_step[i];
            add_report(i, 1'b0);
          end
        end
      end
      KIND_PLAY: begin
        stop_playing(c.step);
        if (c.valid && trk_loaded[c.idx]) begin
          trk_playing[c.idx] = 1'b1;
          if (c.step != '0) trk_step[c.idx] = c.step;
        end
      end
      KIND_STOP: begin
        stop_playing(c.step);
      end
      KIND_RESTART: begin
        if (c.valid && trk_loaded[c.idx]) add_report(int'(c.idx), 1'b1);
      end
      KIND_LOAD: begin
        if (c.valid) begin
          trk_loaded[c.idx]  = 1'b1;
          trk_playing[c.idx] = 1'b0;
          trk_volume[c.idx]  = '0;
          trk_step[c.idx]    = load_step;
          add_report(int'(c.idx), 1'b1);
        end
      end
      KIND_UNLOAD: begin
        // The volume is kept, so an unloaded track keeps fading out.
        if (c.valid && trk_loaded[c.idx]) begin
          trk_loaded[c.idx]  = 1'b0;
          trk_playing[c.idx] = 1'b0;
        end
      end
      KIND_REFRESH: begin
        for (int i = 0; i < N_TRACKS; i++) add_report(i, 1'b0);
      end
      default: begin
        // The spare kind code is dropped without a result.
      end
    endcase
    if (reports_this_cmd > 0) begin
      tail      = level_reports.pop_back();
      tail.last = 1'b1;
      append_report(tail);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------

  // A new beat goes up at the falling edge once the previous one has been
  // taken, unless the sender decides to idle this cycle. A beat that is
  // still waiting is held unchanged.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || cmd_taken)) begin
      cmd_taken = 1'b0;
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_on_bus = cmd_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cmd_on_bus.kind;
        in_tdata  <= {2'b00, cmd_on_bus.step, cmd_on_bus.valid, cmd_on_bus.idx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver
  // ---------------------------------------------------------------------

  // Ready is chosen at the falling edge. A hold-off request from the
  // stimulus thread loads a countdown here; while it runs, ready stays low
  // and the command queue inside the block fills until the input stalls.
  always @(negedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Acceptance, checking and watchdog, all on the rising edge
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : edge_checks
    level_report_t got;
    level_report_t want;
    logic          any_beat;

    any_beat = 1'b0;

    // A command beat taken here updates the model before the next one.
    if (rst_n && in_tvalid && in_tready) begin
      apply_command(cmd_on_bus);
      cmd_taken = 1'b1;
      any_beat  = 1'b1;
    end

    if (rst_n && out_tvalid && out_tready) begin
      any_beat    = 1'b1;
      got.trk     = out_tdata[3:0];
      got.level   = out_tdata[11:4];
      got.restart = out_tdata[12];
      got.last    = out_tlast;
      if (level_reports.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result beat: track %0d level %0d restart %0b last %0b",
                   got.trk, got.level, got.restart, got.last);
      end else begin
        want = level_reports.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch exp/act: trk %0d/%0d lvl %0d/%0d rst %0b/%0b last %0b/%0b",
                     want.trk, got.trk, want.level, got.level,
                     want.restart, got.restart, want.last, got.last);
        end
      end
    end

    // Count only cycles where something is owed and nothing moved.
    if (any_beat) begin
      stall_cycles = 0;
    end else if (in_tvalid || level_reports.size() != 0) begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic void push_cmd(input logic [KIND_W-1:0] kind, input int idx,
                                   input logic valid, input int step);
    track_cmd_t c;
    c.kind  = kind;
    c.idx   = idx[TRK_W-1:0];
    c.valid = valid;
    c.step  = step[VOL_W-1:0];
    append_cmd(c);
  endfunction

  // Mostly meaningful traffic: loads and plays aimed at a few low tracks so
  // ramps build up over ticks, with the occasional invalid track, spare
  // kind code and odd fade step mixed in.
  function automatic track_cmd_t random_cmd();
    track_cmd_t c;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 36)      c.kind = KIND_TICK;
    else if (pick < 51) c.kind = KIND_PLAY;
    else if (pick < 58) c.kind = KIND_STOP;
    else if (pick < 67) c.kind = KIND_RESTART;
    else if (pick < 80) c.kind = KIND_LOAD;
    else if (pick < 88) c.kind = KIND_UNLOAD;
    else if (pick < 96) c.kind = KIND_REFRESH;
    else                c.kind = KIND_UNUSED;
    c.idx   = TRK_W'(($urandom_range(1) != 0) ? $urandom_range(5) : $urandom_range(15));
    c.valid = ($urandom_range(9) != 0);
    pick = $urandom_range(99);
    if (pick < 30)      c.step = '0;
    else if (pick < 40) c.step = Q16_ONE;
    else if (pick < 55) c.step = VOL_W'($urandom_range(65536));
    else                c.step = VOL_W'($urandom_range(20000, 300));
    return c;
  endfunction

  // Write every register; the model's copy follows immediately since the
  // block is idle whenever this runs.
  task automatic set_mix(input int mg, input int gg, input logic ma, input logic mm,
                         input int ds);
    logic [CFG_IDX_W-1:0]  idx_list [5];
    logic [CFG_DATA_W-1:0] val_list [5];
    idx_list = '{CFG_MUSIC_GAIN, CFG_GLOBAL_GAIN, CFG_MUTE_ALL, CFG_MUTE_MUSIC,
                 CFG_DEF_STEP};
    val_list = '{mg[CFG_DATA_W-1:0], gg[CFG_DATA_W-1:0], {16'd0, ma}, {16'd0, mm},
                 ds[CFG_DATA_W-1:0]};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx_list[i];
      cfg_data <= val_list[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    music_gain_q8  = mg & 32'h1FF;
    global_gain_q8 = gg & 32'h1FF;
    mute_all_on    = ma;
    mute_music_on  = mm;
    load_step      = ds[VOL_W-1:0];
  endtask

  // Wait until every queued beat is taken and every report has come back,
  // then give the engine time to finish commands that report nothing.
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_tvalid || level_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  task automatic random_burst();
    for (int i = 0; i < RAND_ITEMS; i++) append_cmd(random_cmd());
  endtask

  initial begin
    for (int i = 0; i < N_TRACKS; i++) begin
      trk_loaded[i]  = 1'b0;
      trk_playing[i] = 1'b0;
      trk_volume[i]  = '0;
      trk_step[i]    = STEP_RESET;
    end

    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase 0: reset settings, sender idles rarely, receiver often.
    send_idle_pct = 14;
    recv_idle_pct = 47;
    set_mix(256, 256, 1'b0, 1'b0, 655);

    // Directed walk through every command and the corner cases.
    push_cmd(KIND_LOAD,    0,  1'b1, 0);       // load reports level 0, restart
    push_cmd(KIND_LOAD,    15, 1'b1, 0);       // highest track index
    push_cmd(KIND_LOAD,    5,  1'b0, 65536);   // invalid load does nothing
    push_cmd(KIND_RESTART, 0,  1'b1, 0);       // restart of a loaded track
    push_cmd(KIND_RESTART, 7,  1'b1, 0);       // restart of an unloaded track
    push_cmd(KIND_PLAY,    0,  1'b1, 65536);   // full step: one tick to full
    push_cmd(KIND_TICK,    0,  1'b0, 0);
    push_cmd(KIND_TICK,    0,  1'b0, 0);       // nothing moves, no result
    push_cmd(KIND_PLAY,    15, 1'b1, 0);       // crossfade, steps kept
    push_cmd(KIND_TICK,    0,  1'b0, 0);
    push_cmd(KIND_STOP,    9,  1'b1, 1);       // smallest nonzero step
    push_cmd(KIND_TICK,    0,  1'b0, 0);
    push_cmd(KIND_UNLOAD,  15, 1'b1, 0);       // unloaded track still fades
    push_cmd(KIND_TICK,    0,  1'b0, 0);
    push_cmd(KIND_UNLOAD,  3,  1'b1, 0);       // unload of an unloaded track
    push_cmd(KIND_REFRESH, 0,  1'b0, 0);       // sixteen results
    push_cmd(KIND_UNUSED,  11, 1'b1, 131071);  // spare code, all step bits set
    push_cmd(KIND_LOAD,    9,  1'b1, 0);
    push_cmd(KIND_PLAY,    9,  1'b0, 0);       // invalid play only stops
    push_cmd(KIND_RESTART, 9,  1'b0, 0);       // invalid restart
    push_cmd(KIND_PLAY,    9,  1'b1, 40000);
    push_cmd(KIND_TICK,    0,  1'b0, 0);
    push_cmd(KIND_TICK,    0,  1'b0, 0);
    push_cmd(KIND_REFRESH, 0,  1'b0, 0);
    random_burst();
    drain();

    // Phase 1: gains above one so levels saturate, and a zero load step,
    // under which a playing track still reports on every tick.
    set_mix(511, 300, 1'b0, 1'b0, 0);
    push_cmd(KIND_LOAD, 2, 1'b1, 0);
    push_cmd(KIND_PLAY, 2, 1'b1, 0);
    push_cmd(KIND_TICK, 0, 1'b0, 0);
    push_cmd(KIND_TICK, 0, 1'b0, 0);
    random_burst();
    drain();

    // Phase 2: sender idles often, receiver rarely; everything muted.
    send_idle_pct = 47;
    recv_idle_pct = 14;
    set_mix(0, 256, 1'b1, 1'b0, 65536);
    random_burst();
    drain();

    // Phase 3: music mute and odd gains.
    set_mix(200, 170, 1'b0, 1'b1, 1);
    random_burst();
    drain();

    // Phase 4: no idling at all. The receiver also holds off for a long
    // stretch while the sender keeps offering beats, so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mix(256, 256, 1'b0, 1'b0, 2000);
    random_burst();
    hold_asked++;
    drain();

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
